// File: hdl/xemr_pkg.sv
// shared types and constants for the xoshiro128++ entropy mixing generator
// no dependencies; imported by xemr_ctrl, xemr_dp and xoshiro_entropy_mixing_rng
`default_nettype none

package xemr_pkg;

  // splitmix32 constants and reseed salt
  localparam logic [31:0] GOLDEN    = 32'h9e37_79b9;
  localparam logic [31:0] MULT_A    = 32'h85eb_ca6b;
  localparam logic [31:0] MULT_B    = 32'hc2b2_ae35;
  localparam logic [31:0] SEED_SALT = 32'ha5a5_f00d;

  // request kinds
  localparam logic [1:0] KIND_RESEED = 2'd0;
  localparam logic [1:0] KIND_MIX    = 2'd1;
  localparam logic [1:0] KIND_GEN    = 2'd2;

  // input request
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] seed_first;
    logic [31:0] seed_second;
    logic [63:0] timestamp;
    logic [31:0] tick_count;
    logic [31:0] mix_value;
    logic [31:0] buffer_address;
    logic [6:0]  byte_count;
  } cmd_item_t;

  // output word
  typedef struct packed {
    logic [31:0] random_word;
    logic [2:0]  valid_bytes;
    logic        last_word;
  } word_item_t;

  // datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_SEED,
    OP_LOAD_MIX,
    OP_LOAD_GEN,
    OP_CTR_MUL,
    OP_ACC_FOLD,
    OP_SM_ADD,
    OP_MUL_A,
    OP_MUL_B,
    OP_SEED_STORE,
    OP_MIX_STORE,
    OP_STEP,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic idx_last;   // seeding the last generator word
    logic len_zero;   // no bytes left to emit
    logic gen_last;   // next word closes the request
    logic out_free;   // output register can take a word
  } dp_status_t;

endpackage

`default_nettype wire

// File: hdl/xemr_dp.sv
// datapath: generator words, mix counter, shared splitmix multiplier, output register
// depends on xemr_pkg
`default_nettype none

module xemr_dp import xemr_pkg::*; #(
  parameter int MAX_REQUEST_BYTES = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cmd_item_t  item,
  input  wire dp_cmd_t    dcmd,
  output dp_status_t      status,
  output logic            word_valid,
  input  wire logic       word_stall,
  output word_item_t      word
);

  localparam int LEN_W = $clog2(MAX_REQUEST_BYTES + 1);

  logic [31:0]      gen_words [4];
  logic [31:0]      ctr;
  logic [31:0]      acc;
  logic [31:0]      prod;
  logic [1:0]       seed_idx;
  logic [LEN_W-1:0] left;

  logic [31:0]      fold;
  logic             cap;
  logic [LEN_W-1:0] len_c;
  logic [31:0]      mul_a;
  logic [31:0]      mul_b;
  logic [31:0]      mul_full;
  logic [31:0]      sm_out;
  logic [31:0]      step_sum;
  logic [31:0]      step_res;
  logic [31:0]      t0, t1, t2, t3, sh;
  logic [31:0]      nw0, nw1, nw2, nw3;

  assign fold  = item.timestamp[31:0] ^ item.timestamp[63:32];
  assign cap   = 32'(item.byte_count) > 32'(MAX_REQUEST_BYTES);
  assign len_c = cap ? LEN_W'(MAX_REQUEST_BYTES) : LEN_W'(item.byte_count);

  // shared multiplier operand select
  always_comb begin
    case (dcmd.op)
      OP_CTR_MUL: begin
        mul_a = ctr;
        mul_b = GOLDEN;
      end
      OP_MUL_A: begin
        mul_a = acc ^ {16'd0, acc[31:16]};
        mul_b = MULT_A;
      end
      default: begin
        mul_a = prod ^ {13'd0, prod[31:13]};
        mul_b = MULT_B;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;
  assign sm_out   = prod ^ {16'd0, prod[31:16]};

  // xoshiro128++ step
  assign step_sum = gen_words[0] + gen_words[3];
  assign step_res = {step_sum[24:0], step_sum[31:25]} + gen_words[0];
  assign sh       = {gen_words[1][22:0], 9'd0};
  assign t2       = gen_words[2] ^ gen_words[0];
  assign t3       = gen_words[3] ^ gen_words[1];
  assign t1       = gen_words[1] ^ t2;
  assign t0       = gen_words[0] ^ t3;
  assign nw0      = t0;
  assign nw1      = t1;
  assign nw2      = t2 ^ sh;
  assign nw3      = {t3[20:0], t3[31:21]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) gen_words[i] <= '0;
      ctr <= '0;
    end else begin
      case (dcmd.op)
        OP_LOAD_SEED: begin
          acc      <= item.seed_first ^ {item.seed_second[18:0], item.seed_second[31:19]}
                      ^ fold ^ SEED_SALT;
          seed_idx <= '0;
          left     <= '0;
        end
        OP_LOAD_MIX: begin
          ctr  <= ctr + 32'd1;
          acc  <= item.mix_value ^ fold ^ item.tick_count;
          left <= '0;
        end
        OP_LOAD_GEN: begin
          ctr  <= ctr + 32'd1;
          acc  <= item.buffer_address ^ 32'(len_c) ^ fold ^ item.tick_count;
          left <= len_c;
        end
        OP_CTR_MUL, OP_MUL_A, OP_MUL_B: prod <= mul_full;
        OP_ACC_FOLD: acc <= acc ^ prod;
        OP_SM_ADD:   acc <= acc + GOLDEN;
        OP_SEED_STORE: begin
          gen_words[seed_idx] <= sm_out;
          seed_idx            <= seed_idx + 2'd1;
          if (seed_idx == 2'd3) ctr <= acc;
        end
        OP_MIX_STORE: gen_words[ctr[1:0]] <= gen_words[ctr[1:0]] ^ sm_out;
        OP_STEP: begin
          gen_words[0] <= nw0;
          gen_words[1] <= nw1;
          gen_words[2] <= nw2;
          gen_words[3] <= nw3;
        end
        OP_EMIT: begin
          gen_words[0] <= nw0;
          gen_words[1] <= nw1;
          gen_words[2] <= nw2;
          gen_words[3] <= nw3;
          word.random_word <= step_res;
          word.valid_bytes <= status.gen_last ? left[2:0] : 3'd4;
          word.last_word   <= status.gen_last;
          left             <= status.gen_last ? '0 : left - LEN_W'(4);
        end
        default: ;
      endcase
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (dcmd.op == OP_EMIT) begin
      word_valid <= 1'b1;
    end else if (!word_stall) begin
      word_valid <= 1'b0;
    end
  end

  // the closing word reports the one to four bytes still left
  always_comb begin
    status.idx_last = seed_idx == 2'd3;
    status.len_zero = left == '0;
    status.gen_last = left <= LEN_W'(4);
    status.out_free = !word_valid || !word_stall;
  end

endmodule

`default_nettype wire

// File: hdl/xemr_ctrl.sv
// controller: sequences reseed, mix and generate requests through the datapath
// depends on xemr_pkg
`default_nettype none

module xemr_ctrl import xemr_pkg::*; #(
  parameter int WARMUP_STEPS = 16,
  parameter int MIX_STEPS    = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cmd_valid,
  input  wire logic [1:0] kind,
  input  wire dp_status_t status,
  output dp_cmd_t         dcmd,
  output logic            busy
);

  localparam int STEP_MAX = (WARMUP_STEPS > MIX_STEPS) ? WARMUP_STEPS : MIX_STEPS;
  localparam int STEP_W   = (STEP_MAX < 1) ? 1 : $clog2(STEP_MAX + 1);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_CTR_MUL  = 9'b000000010,
    S_ACC_FOLD = 9'b000000100,
    S_SM_ADD   = 9'b000001000,
    S_MUL_A    = 9'b000010000,
    S_MUL_B    = 9'b000100000,
    S_SM_FIN   = 9'b001000000,
    S_STEP     = 9'b010000000,
    S_EMIT     = 9'b100000000
  } state_t;

  state_t              state, state_next;
  logic [STEP_W-1:0]   steps, steps_next;
  logic                reseeding, reseeding_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      steps     <= '0;
      reseeding <= 1'b0;
    end else begin
      state     <= state_next;
      steps     <= steps_next;
      reseeding <= reseeding_next;
    end
  end

  always_comb begin
    state_next     = state;
    steps_next     = steps;
    reseeding_next = reseeding;
    dcmd.op        = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          unique case (kind)
            KIND_RESEED: begin
              dcmd.op        = OP_LOAD_SEED;
              reseeding_next = 1'b1;
              state_next     = S_SM_ADD;
            end
            KIND_MIX: begin
              dcmd.op        = OP_LOAD_MIX;
              reseeding_next = 1'b0;
              state_next     = S_CTR_MUL;
            end
            KIND_GEN: begin
              dcmd.op        = OP_LOAD_GEN;
              reseeding_next = 1'b0;
              state_next     = S_CTR_MUL;
            end
            default: ;  // unknown kind is dropped
          endcase
        end
      end
      S_CTR_MUL: begin
        dcmd.op    = OP_CTR_MUL;
        state_next = S_ACC_FOLD;
      end
      S_ACC_FOLD: begin
        dcmd.op    = OP_ACC_FOLD;
        state_next = S_SM_ADD;
      end
      S_SM_ADD: begin
        dcmd.op    = OP_SM_ADD;
        state_next = S_MUL_A;
      end
      S_MUL_A: begin
        dcmd.op    = OP_MUL_A;
        state_next = S_MUL_B;
      end
      S_MUL_B: begin
        dcmd.op    = OP_MUL_B;
        state_next = S_SM_FIN;
      end
      S_SM_FIN: begin
        if (reseeding) begin
          dcmd.op = OP_SEED_STORE;
          if (!status.idx_last) begin
            state_next = S_SM_ADD;
          end else begin
            steps_next = STEP_W'(WARMUP_STEPS);
            state_next = (WARMUP_STEPS == 0) ? S_IDLE : S_STEP;
          end
        end else begin
          dcmd.op    = OP_MIX_STORE;
          steps_next = STEP_W'(MIX_STEPS);
          if (MIX_STEPS != 0) begin
            state_next = S_STEP;
          end else begin
            state_next = status.len_zero ? S_IDLE : S_EMIT;
          end
        end
      end
      S_STEP: begin
        dcmd.op = OP_STEP;
        if (steps == STEP_W'(1)) begin
          state_next = status.len_zero ? S_IDLE : S_EMIT;
        end else begin
          steps_next = steps - STEP_W'(1);
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          dcmd.op = OP_EMIT;
          if (status.gen_last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = state != S_IDLE;

endmodule

`default_nettype wire

// File: hdl/xoshiro_entropy_mixing_rng.sv
// reseed: seed load, a splitmix round per generator word, then WARMUP_STEPS warm-up steps
// mix: load, counter multiply and fold, one splitmix round, then MIX_STEPS steps
// generate: as mix, then words are emitted while the output register is free
// one request at a time; the single shared multiplier makes the splitmix rounds serial
// reset: synchronous, active high; generator words and mix counter cleared,
// output register emptied, controller idle
`default_nettype none

module xoshiro_entropy_mixing_rng import xemr_pkg::*; #(
  parameter int MAX_REQUEST_BYTES = 64,
  parameter int WARMUP_STEPS      = 16,
  parameter int MIX_STEPS         = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        cmd_valid,
  output logic             cmd_stall,
  input  wire cmd_item_t   cmd,
  // generated words
  output logic             word_valid,
  input  wire logic        word_stall,
  output word_item_t       word
);

  dp_cmd_t    dcmd;
  dp_status_t status;
  logic       busy;

  // controller walks each request through load, splitmix round(s),
  // generator steps and, for generate requests, word emission
  xemr_ctrl #(
    .WARMUP_STEPS (WARMUP_STEPS),
    .MIX_STEPS    (MIX_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .kind      (cmd.kind),
    .status    (status),
    .dcmd      (dcmd),
    .busy      (busy)
  );

  // datapath holds the state words, counter, multiplier and output register
  xemr_dp #(
    .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .item       (cmd),
    .dcmd       (dcmd),
    .status     (status),
    .word_valid (word_valid),
    .word_stall (word_stall),
    .word       (word)
  );

  // requests are taken only while the controller is idle
  assign cmd_stall = busy;

  // a word is loaded only while a request is in progress
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    dcmd.op == OP_EMIT |-> cmd_stall)
    else $error("word emitted outside a request");

  // a word is loaded only when the output register can take it
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    dcmd.op == OP_EMIT |-> (!word_valid || !word_stall))
    else $error("output word overwritten");

  // only the closing word of a request may be partial
  a_full_word: assert property (@(posedge clk) disable iff (rst)
    (word_valid && !word.last_word) |-> word.valid_bytes == 3'd4)
    else $error("partial word before end of request");

  // every word carries one to four bytes
  a_byte_range: assert property (@(posedge clk) disable iff (rst)
    word_valid |-> (word.valid_bytes != 3'd0 && word.valid_bytes <= 3'd4))
    else $error("byte count out of range");

endmodule

`default_nettype wire
